[src/hfrst_pkg.sv]
// ----------------------------------------------------------------------------
// hfrst_pkg
// Shared types and codes of the huge frame reclaim state table.
// ----------------------------------------------------------------------------
package hfrst_pkg;

	localparam int FRAME_W    = 22;
	localparam int KIND_W     = 3;
	localparam int CNT_W      = 14;
	localparam int TREE_CNT_W = 12;  // holds ceil((2**CNT_W - 1) / 8)
	localparam int WORD_W     = 16;
	localparam int CHILD_W    = 3;

	localparam logic [CNT_W-1:0] CNT_RESET = 14'd8192;

	// operation kinds
	localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_HARD    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_SOFT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_INSTALL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd4;

	// result status
	localparam logic [1:0] STAT_DONE     = 2'd0;
	localparam logic [1:0] STAT_MISMATCH = 2'd1;
	localparam logic [1:0] STAT_RANGE    = 2'd2;
	localparam logic [1:0] STAT_NO_HARD  = 2'd3;

	// reclaim states
	localparam logic [1:0] RS_INSTALLED = 2'd0;
	localparam logic [1:0] RS_SOFT      = 2'd1;
	localparam logic [1:0] RS_HARD      = 2'd2;

	typedef struct packed {
		logic [1:0]         cur;       // state of the selected child
		logic               hard_any;  // some child of the word is hard
		logic [CHILD_W-1:0] hard_idx;  // lowest hard child
	} child_info_t;

endpackage

[src/huge_frame_reclaim_state_table.sv]
// ----------------------------------------------------------------------------
// huge_frame_reclaim_state_table
// Reclaim state per huge frame, eight 2-bit states per tree word in RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | kind, frame, from_soft
//  out     | output    | out_valid / out_stall| status, old_state, found_frame
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (huge_frame_count)
//
//  single-frame items pass transfer, RAM read and write back; out of range ones skip the RAM.
//  return next reads from the scan start until a hit or until all active trees are read, one
//  tree read per cycle; a stale scan start is first reduced modulo the number of trees.
//  after reset a clearing pass writes NUM_TREES words, one per cycle, with
//  in_stall high; configuration writes are taken during it.
//  a new item is taken while a result still waits on out_stall.
// ----------------------------------------------------------------------------
module huge_frame_reclaim_state_table
	import hfrst_pkg::*;
#(
	parameter int HUGE_ORDER = 9,
	parameter int NUM_TREES  = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [KIND_W-1:0]  kind,
	input  logic [FRAME_W-1:0] frame,
	input  logic               from_soft,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [1:0]         old_state,
	output logic [FRAME_W-1:0] found_frame,
	input  logic               cfg_wr_en,
	input  logic [CNT_W-1:0]   cfg_wr_data
);

	localparam int AW      = (NUM_TREES > 1) ? $clog2(NUM_TREES) : 1;
	localparam int CAP     = 8 * NUM_TREES;
	localparam int CAP_SAT = (CAP > (2**CNT_W - 1)) ? (2**CNT_W - 1) : CAP;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_PEND, S_EXEC, S_MOD, S_SCAN
	} fsm_t;

	fsm_t                  state_q;
	logic [AW-1:0]         clr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TREE_CNT_W-1:0] scan_q;
	logic [KIND_W-1:0]     kind_q;
	logic [FRAME_W-1:0]    frame_q;
	logic                  from_soft_q;
	logic [TREE_CNT_W-1:0] rem_q;
	logic [3:0]            bit_q;
	logic [TREE_CNT_W-1:0] t_q;
	logic [TREE_CNT_W-1:0] n_q;
	logic                  rdv_s1;
	logic [TREE_CNT_W-1:0] rd_tree_s1;
	logic                  out_valid_q;
	logic [1:0]            status_q;
	logic [1:0]            old_q;
	logic [FRAME_W-1:0]    found_q;

	logic [CNT_W-1:0]      eff;
	logic [TREE_CNT_W-1:0] trees;
	logic [FRAME_W-1:0]    huge;
	logic                  out_range;
	logic [AW-1:0]         item_tree;
	logic [CHILD_W-1:0]    item_child;
	logic                  change;
	logic [1:0]            from_st;
	logic [1:0]            to_st;
	logic                  hit;
	logic                  scan_done;
	logic [TREE_CNT_W-1:0] rem_shift;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [WORD_W-1:0]     wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [WORD_W-1:0]     rd_data;
	child_info_t           info;
	logic [WORD_W-1:0]     new_word;

	hfrst_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_TREES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	hfrst_word_op u_word (
		.word     (rd_data),
		.sel_child(item_child),
		.use_hard (state_q == S_SCAN),
		.new_state((state_q == S_SCAN) ? RS_SOFT : to_st),
		.info     (info),
		.new_word (new_word)
	);

	// effective frame count and number of active trees
	assign eff   = (cnt_q < CNT_W'(CAP_SAT)) ? cnt_q : CNT_W'(CAP_SAT);
	assign trees = TREE_CNT_W'(eff[CNT_W-1:3]) + TREE_CNT_W'(|eff[2:0]);

	assign huge       = frame_q >> HUGE_ORDER;
	assign out_range  = huge >= FRAME_W'(eff);
	assign item_tree  = AW'(huge >> 3);
	assign item_child = huge[CHILD_W-1:0];

	always_comb begin
		change  = 1'b1;
		from_st = RS_INSTALLED;
		to_st   = RS_INSTALLED;
		unique case (kind_q)
			KIND_HARD: begin
				from_st = from_soft_q ? RS_SOFT : RS_INSTALLED;
				to_st   = RS_HARD;
			end
			KIND_SOFT: begin
				from_st = RS_INSTALLED;
				to_st   = RS_SOFT;
			end
			KIND_INSTALL: begin
				from_st = RS_SOFT;
				to_st   = RS_INSTALLED;
			end
			default: change = 1'b0;
		endcase
	end

	assign hit       = (state_q == S_SCAN) && rdv_s1 && info.hard_any;
	assign scan_done = (n_q == trees);
	assign rem_shift = {rem_q[TREE_CNT_W-2:0], scan_q[bit_q]};

	// RAM requests
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = item_tree;
		wr_data = new_word;
		rd_en   = 1'b0;
		rd_addr = item_tree;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			S_PEND: begin
				rd_en = !out_valid_q && (kind_q != KIND_NEXT) && !out_range;
			end
			S_EXEC: begin
				wr_en = change && (info.cur == from_st);
			end
			S_SCAN: begin
				wr_en   = hit;
				wr_addr = AW'(rd_tree_s1);
				rd_en   = !hit && !scan_done;
				rd_addr = AW'(t_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cnt_q       <= CNT_RESET;
			scan_q      <= '0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cnt_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == AW'(NUM_TREES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						clr_q <= clr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						kind_q      <= kind;
						frame_q     <= frame;
						from_soft_q <= from_soft;
						state_q     <= S_PEND;
					end
				end
				S_PEND: begin
					// wait for the output slot before any RAM work
					if (!out_valid_q) begin
						if (kind_q == KIND_NEXT) begin
							if (trees == '0) begin
								out_valid_q <= 1'b1;
								status_q    <= STAT_NO_HARD;
								old_q       <= RS_INSTALLED;
								found_q     <= '0;
								state_q     <= S_IDLE;
							end else if (scan_q >= trees) begin
								rem_q   <= '0;
								bit_q   <= 4'(TREE_CNT_W - 1);
								state_q <= S_MOD;
							end else begin
								t_q     <= scan_q;
								n_q     <= '0;
								rdv_s1  <= 1'b0;
								state_q <= S_SCAN;
							end
						end else if (out_range) begin
							out_valid_q <= 1'b1;
							status_q    <= STAT_RANGE;
							old_q       <= RS_INSTALLED;
							found_q     <= '0;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					out_valid_q <= 1'b1;
					status_q    <= (change && (info.cur != from_st)) ? STAT_MISMATCH
					                                                 : STAT_DONE;
					old_q       <= info.cur;
					found_q     <= '0;
					state_q     <= S_IDLE;
				end
				S_MOD: begin
					// restoring remainder of a stale scan start, one bit a cycle
					if (rem_shift >= trees) begin
						rem_q <= rem_shift - trees;
					end else begin
						rem_q <= rem_shift;
					end
					if (bit_q == '0) begin
						t_q     <= (rem_shift >= trees) ? rem_shift - trees : rem_shift;
						n_q     <= '0;
						rdv_s1  <= 1'b0;
						state_q <= S_SCAN;
					end else begin
						bit_q <= bit_q - 4'd1;
					end
				end
				S_SCAN: begin
					if (hit) begin
						scan_q      <= rd_tree_s1;
						out_valid_q <= 1'b1;
						status_q    <= STAT_DONE;
						old_q       <= RS_HARD;
						found_q     <= FRAME_W'({rd_tree_s1, info.hard_idx}) << HUGE_ORDER;
						rdv_s1      <= 1'b0;
						state_q     <= S_IDLE;
					end else if (scan_done && !rdv_s1) begin
						out_valid_q <= 1'b1;
						status_q    <= STAT_NO_HARD;
						old_q       <= RS_INSTALLED;
						found_q     <= '0;
						state_q     <= S_IDLE;
					end else if (!scan_done) begin
						rdv_s1     <= 1'b1;
						rd_tree_s1 <= t_q;
						n_q        <= n_q + TREE_CNT_W'(1);
						t_q        <= (t_q == trees - TREE_CNT_W'(1)) ? '0
						                                              : t_q + TREE_CNT_W'(1);
					end else begin
						rdv_s1 <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign old_state   = old_q;
	assign found_frame = found_q;

endmodule

[src/hfrst_ram.sv]
// ----------------------------------------------------------------------------
// hfrst_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hfrst_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/hfrst_word_op.sv]
// ----------------------------------------------------------------------------
// hfrst_word_op
// Decodes one packed tree word: selected child state, first hard child,
// and the word with one child replaced.
// ----------------------------------------------------------------------------
module hfrst_word_op
	import hfrst_pkg::*;
(
	input  logic [WORD_W-1:0]  word,
	input  logic [CHILD_W-1:0] sel_child,
	input  logic               use_hard,   // replace the first hard child instead
	input  logic [1:0]         new_state,
	output child_info_t        info,
	output logic [WORD_W-1:0]  new_word
);

	logic [CHILD_W-1:0] tgt;

	always_comb begin
		info.cur      = word[2*sel_child +: 2];
		info.hard_any = 1'b0;
		info.hard_idx = '0;
		// highest first so the lowest hard child wins
		for (int c = 7; c >= 0; c--) begin
			if (word[2*c +: 2] == RS_HARD) begin
				info.hard_any = 1'b1;
				info.hard_idx = CHILD_W'(c);
			end
		end
	end

	always_comb begin
		tgt      = use_hard ? info.hard_idx : sel_child;
		new_word = word;
		new_word[2*tgt +: 2] = new_state;
	end

endmodule
